[hw/rtl/isg_pkg.sv]
// Shared types and constants for the Ising Metropolis spin-update engine.
// No dependencies; used by isg_count_bank and ising_metropolis_spin_update.
package isg_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int SITES_DEF         = 4096;
    localparam int MAX_NEIGHBORS_DEF = 6;
    localparam int COUNT_BITS_DEF    = 32;

    // Fixed field widths of the item and result beats
    localparam int ITEM_SITE_W = 12;
    localparam int SITE_LIMIT  = 2**ITEM_SITE_W - 1;
    localparam int SLOT_W      = 3;
    localparam int TRIAL_W     = 16;
    localparam int CNT_OUT_W   = 32;
    localparam int DE_W        = 5;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NBR_COUNT_W = 3;
    localparam int THR_COUNT   = 6;

    localparam logic [CFG_IDX_W-1:0]   CFG_NBR_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0]   CFG_THR_FIRST   = 3'd1;
    localparam logic [NBR_COUNT_W-1:0] NBR_COUNT_RESET = 3'd4;

    // Item kinds
    localparam logic [1:0] KIND_NBR  = 2'd0;
    localparam logic [1:0] KIND_SPIN = 2'd1;
    localparam logic [1:0] KIND_MOVE = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic [ITEM_SITE_W-1:0] site;
        logic [SLOT_W-1:0]      slot;
        logic [ITEM_SITE_W-1:0] neighbor_site;
        logic                   spin_up;
        logic [TRIAL_W-1:0]     trial;
    } t_item;

    typedef struct packed {
        logic signed [DE_W-1:0] energy_change;
        logic                   accepted;
        logic                   new_spin;
        logic [CNT_OUT_W-1:0]   pick_count;
        logic [CNT_OUT_W-1:0]   accept_count;
        logic [CNT_OUT_W-1:0]   reject_count;
    } t_result;

    // Counter update request from the sequencer to the counter bank
    typedef struct packed {
        logic en;
        logic accepted;
    } t_cnt_upd;

endpackage

[hw/rtl/isg_count_bank.sv]
// Per-site saturating pick/accept/reject counters with a clearing pass after reset.
// Depends on isg_pkg (t_cnt_upd).
module isg_count_bank #(
    parameter int SITES      = isg_pkg::SITES_DEF,
    parameter int COUNT_BITS = isg_pkg::COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(SITES)-1:0] i_addr,
    input  isg_pkg::t_cnt_upd        i_upd,
    output logic                     o_busy,
    output logic [COUNT_BITS-1:0]    o_pick,
    output logic [COUNT_BITS-1:0]    o_acc,
    output logic [COUNT_BITS-1:0]    o_rej
);

    localparam int SITE_W = $clog2(SITES);
    localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(SITES - 1);

    logic [COUNT_BITS-1:0] r_pick_mem [SITES];
    logic [COUNT_BITS-1:0] r_acc_mem  [SITES];
    logic [COUNT_BITS-1:0] r_rej_mem  [SITES];
    logic [COUNT_BITS-1:0] r_pick_q, r_acc_q, r_rej_q;
    logic [COUNT_BITS-1:0] n_pick, n_acc, n_rej;
    logic                  r_busy;
    logic [SITE_W-1:0]     r_clr_addr;

    // Saturating increments of the read beat
    assign n_pick = (&r_pick_q) ? r_pick_q : r_pick_q + 1'b1;
    assign n_acc  = (&r_acc_q)  ? r_acc_q  : r_acc_q + 1'b1;
    assign n_rej  = (&r_rej_q)  ? r_rej_q  : r_rej_q + 1'b1;

    // Updated values on an update cycle, plain read data otherwise
    assign o_pick = i_upd.en ? n_pick : r_pick_q;
    assign o_acc  = (i_upd.en && i_upd.accepted)  ? n_acc : r_acc_q;
    assign o_rej  = (i_upd.en && !i_upd.accepted) ? n_rej : r_rej_q;
    assign o_busy = r_busy;

    // Clearing sweep, one site per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == LAST_SITE) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Counter memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_pick_mem[r_clr_addr] <= '0;
            r_acc_mem[r_clr_addr]  <= '0;
            r_rej_mem[r_clr_addr]  <= '0;
        end else if (i_upd.en) begin
            r_pick_mem[i_addr] <= o_pick;
            r_acc_mem[i_addr]  <= o_acc;
            r_rej_mem[i_addr]  <= o_rej;
        end
        if (i_rd_en) begin
            r_pick_q <= r_pick_mem[i_addr];
            r_acc_q  <= r_acc_mem[i_addr];
            r_rej_q  <= r_rej_mem[i_addr];
        end
    end

endmodule

[hw/rtl/ising_metropolis_spin_update.sv]
// Top level of the Metropolis single-spin-flip engine: sequencer, spin store,
// neighbor table and config registers. Depends on isg_pkg and isg_count_bank.
//
//  channel   signals                                   direction  beat taken when
//  item      start, busy, i_item                       in         start && !busy
//  result    o_res_valid, o_res                        out        o_res_valid (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    in         i_cfg_valid && o_cfg_ready
//            i_cfg_data
//
// A move reads the neighbor table once per summed slot (the configured neighbor count,
// capped at MAX_NEIGHBORS), each read feeding a spin store read, then does the site's
// spin and counter read-modify-write. Load items take no neighbor pass. When SITES is
// below 4096, site indices are first reduced by a shift-subtract unit.
// After reset the counter bank clears one site per cycle, with busy high.
// Results cannot be stalled; config beats are always taken.
module ising_metropolis_spin_update #(
    parameter int SITES         = isg_pkg::SITES_DEF,
    parameter int MAX_NEIGHBORS = isg_pkg::MAX_NEIGHBORS_DEF,
    parameter int COUNT_BITS    = isg_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  isg_pkg::t_item                   i_item,
    output logic                             o_res_valid,
    output isg_pkg::t_result                 o_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [isg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [isg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SITE_W   = $clog2(SITES);
    localparam int NB_DEPTH = SITES * MAX_NEIGHBORS;
    localparam int NB_AW    = $clog2(NB_DEPTH);
    localparam int IDX_W    = $clog2(MAX_NEIGHBORS + 1);
    localparam int IW       = isg_pkg::ITEM_SITE_W;
    localparam bit NEED_RED = (SITES <= isg_pkg::SITE_LIMIT);
    localparam int RED_TOP  = NEED_RED ? ($clog2(isg_pkg::SITE_LIMIT / SITES + 1) - 1) : 0;
    localparam int RED_KW   = (RED_TOP > 0) ? $clog2(RED_TOP + 1) : 1;
    localparam logic [IW:0] SITES_RED = (IW + 1)'(NEED_RED ? SITES : 0);
    localparam logic [IDX_W-1:0] MAX_NB = IDX_W'(MAX_NEIGHBORS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_PREP,
        S_LOAD,
        S_LOAD_OUT,
        S_GATHER,
        S_SITE,
        S_EVAL
    } t_state;

    t_state r_state;

    // Config registers
    logic [isg_pkg::NBR_COUNT_W-1:0] r_nbr_count;
    logic [isg_pkg::TRIAL_W-1:0]     r_thr [isg_pkg::THR_COUNT];

    // Item registers
    logic [1:0]                  r_kind;
    logic [IW-1:0]               r_site_raw;
    logic [IW-1:0]               r_nsite_raw;
    logic [isg_pkg::SLOT_W-1:0]  r_slot;
    logic                        r_spin_up;
    logic [isg_pkg::TRIAL_W-1:0] r_trial;
    logic [RED_KW-1:0]           r_red_k;
    logic [NB_AW-1:0]            r_nb_base;
    logic [IDX_W-1:0]            r_idx;
    logic [IDX_W-1:0]            r_n_eff;
    logic                        r_v1, r_v2;
    logic signed [3:0]           r_sum;
    logic                        r_res_valid;
    isg_pkg::t_result            r_res;

    // Memories
    logic                r_spin_mem [SITES];
    logic [SITE_W-1:0]   r_nbr_mem  [NB_DEPTH];
    logic                r_spin_q;
    logic [SITE_W-1:0]   r_nbr_q;

    logic                spin_we, spin_wdata, spin_re;
    logic [SITE_W-1:0]   spin_waddr, spin_raddr;
    logic                nbr_we, nbr_re;
    logic [NB_AW-1:0]    nbr_waddr, nbr_raddr;
    logic                cnt_re;
    isg_pkg::t_cnt_upd   cnt_upd;
    logic                clr_busy;
    logic [COUNT_BITS-1:0] cnt_pick, cnt_acc, cnt_rej;

    logic [SITE_W-1:0]   site_w, nsite_w;
    logic [IW:0]         red_div;
    logic signed [3:0]   mag;
    logic signed [isg_pkg::DE_W-1:0] de;
    logic                de_pos;
    logic [2:0]          thr_idx;
    logic [isg_pkg::TRIAL_W-1:0] thr;
    logic                acc;

    assign site_w      = SITE_W'(r_site_raw);
    assign nsite_w     = SITE_W'(r_nsite_raw);
    assign red_div     = SITES_RED << r_red_k;
    assign busy        = (r_state != S_IDLE) || clr_busy;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Energy change and acceptance test
    assign mag    = r_spin_q ? r_sum : -r_sum;
    assign de     = {mag, 1'b0};
    assign de_pos = !mag[3] && (mag != 4'sd0);
    assign thr_idx = 3'(mag - 4'sd1);

    always_comb begin
        case (thr_idx)
            3'd0:    thr = r_thr[0];
            3'd1:    thr = r_thr[1];
            3'd2:    thr = r_thr[2];
            3'd3:    thr = r_thr[3];
            3'd4:    thr = r_thr[4];
            3'd5:    thr = r_thr[5];
            default: thr = '0;
        endcase
    end

    assign acc = !de_pos || (r_trial < thr);

    // Memory port control
    always_comb begin
        spin_we     = 1'b0;
        spin_wdata  = r_spin_up;
        spin_waddr  = site_w;
        spin_re     = 1'b0;
        spin_raddr  = site_w;
        nbr_we      = 1'b0;
        nbr_waddr   = r_nb_base + NB_AW'(r_slot);
        nbr_re      = 1'b0;
        nbr_raddr   = r_nb_base + NB_AW'(r_idx);
        cnt_re      = 1'b0;
        cnt_upd     = '0;
        case (r_state)
            S_LOAD: begin
                spin_re = 1'b1;
                cnt_re  = 1'b1;
                nbr_we  = (r_kind == isg_pkg::KIND_NBR) && (r_slot < MAX_NEIGHBORS);
                spin_we = (r_kind == isg_pkg::KIND_SPIN);
            end
            S_GATHER: begin
                nbr_re     = (r_idx < r_n_eff);
                spin_re    = r_v1;
                spin_raddr = r_nbr_q;
            end
            S_SITE: begin
                spin_re = 1'b1;
                cnt_re  = 1'b1;
            end
            S_EVAL: begin
                spin_we          = acc;
                spin_wdata       = !r_spin_q;
                cnt_upd.en       = 1'b1;
                cnt_upd.accepted = acc;
            end
            default: begin
            end
        endcase
    end

    // Spin store and neighbor table
    always_ff @(posedge i_clk) begin
        if (spin_we) begin
            r_spin_mem[spin_waddr] <= spin_wdata;
        end
        if (spin_re) begin
            r_spin_q <= r_spin_mem[spin_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nbr_we) begin
            r_nbr_mem[nbr_waddr] <= nsite_w;
        end
        if (nbr_re) begin
            r_nbr_q <= r_nbr_mem[nbr_raddr];
        end
    end

    isg_count_bank #(
        .SITES      (SITES),
        .COUNT_BITS (COUNT_BITS)
    ) u_count_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (cnt_re),
        .i_addr  (site_w),
        .i_upd   (cnt_upd),
        .o_busy  (clr_busy),
        .o_pick  (cnt_pick),
        .o_acc   (cnt_acc),
        .o_rej   (cnt_rej)
    );

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbr_count <= isg_pkg::NBR_COUNT_RESET;
            for (int i = 0; i < isg_pkg::THR_COUNT; i++) begin
                r_thr[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == isg_pkg::CFG_NBR_COUNT) begin
                r_nbr_count <= i_cfg_data[isg_pkg::NBR_COUNT_W-1:0];
            end
            for (int i = 0; i < isg_pkg::THR_COUNT; i++) begin
                if (i_cfg_index == isg_pkg::CFG_IDX_W'(i) + isg_pkg::CFG_THR_FIRST) begin
                    r_thr[i] <= i_cfg_data;
                end
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start && !clr_busy) begin
                        r_kind      <= i_item.kind;
                        r_site_raw  <= i_item.site;
                        r_nsite_raw <= i_item.neighbor_site;
                        r_slot      <= i_item.slot;
                        r_spin_up   <= i_item.spin_up;
                        r_trial     <= i_item.trial;
                        r_red_k     <= RED_KW'(RED_TOP);
                        r_state     <= NEED_RED ? S_REDUCE : S_PREP;
                    end
                end
                // one restoring step per cycle on both site indices
                S_REDUCE: begin
                    if ({1'b0, r_site_raw} >= red_div) begin
                        r_site_raw <= r_site_raw - red_div[IW-1:0];
                    end
                    if ({1'b0, r_nsite_raw} >= red_div) begin
                        r_nsite_raw <= r_nsite_raw - red_div[IW-1:0];
                    end
                    if (r_red_k == '0) begin
                        r_state <= S_PREP;
                    end else begin
                        r_red_k <= r_red_k - 1'b1;
                    end
                end
                S_PREP: begin
                    r_nb_base <= NB_AW'(site_w) * NB_AW'(MAX_NEIGHBORS);
                    r_idx     <= '0;
                    r_v1      <= 1'b0;
                    r_v2      <= 1'b0;
                    r_sum     <= '0;
                    r_n_eff   <= (r_nbr_count > MAX_NEIGHBORS) ? MAX_NB : IDX_W'(r_nbr_count);
                    r_state   <= (r_kind == isg_pkg::KIND_MOVE) ? S_GATHER : S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_LOAD_OUT;
                end
                S_LOAD_OUT: begin
                    r_res.energy_change <= '0;
                    r_res.accepted      <= 1'b0;
                    r_res.new_spin      <= (r_kind == isg_pkg::KIND_SPIN) ? r_spin_up : r_spin_q;
                    r_res.pick_count    <= isg_pkg::CNT_OUT_W'(cnt_pick);
                    r_res.accept_count  <= isg_pkg::CNT_OUT_W'(cnt_acc);
                    r_res.reject_count  <= isg_pkg::CNT_OUT_W'(cnt_rej);
                    r_res_valid         <= 1'b1;
                    r_state             <= S_IDLE;
                end
                // table read -> spin read -> accumulate, overlapped per slot
                S_GATHER: begin
                    r_idx <= r_idx + IDX_W'(nbr_re);
                    r_v1  <= nbr_re;
                    r_v2  <= r_v1;
                    if (r_v2) begin
                        r_sum <= r_spin_q ? r_sum + 4'sd1 : r_sum - 4'sd1;
                    end
                    if (!nbr_re && !r_v1 && !r_v2) begin
                        r_state <= S_SITE;
                    end
                end
                S_SITE: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_res.energy_change <= de;
                    r_res.accepted      <= acc;
                    r_res.new_spin      <= acc ? !r_spin_q : r_spin_q;
                    r_res.pick_count    <= isg_pkg::CNT_OUT_W'(cnt_pick);
                    r_res.accept_count  <= isg_pkg::CNT_OUT_W'(cnt_acc);
                    r_res.reject_count  <= isg_pkg::CNT_OUT_W'(cnt_rej);
                    r_res_valid         <= 1'b1;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result strobe only follows the two result-producing states
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> ($past(r_state) == S_EVAL || $past(r_state) == S_LOAD_OUT))
        else $error("result strobe without a finishing state");

    // No item runs while the counter bank is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> (r_state == S_IDLE && !r_res_valid))
        else $error("item in flight during counter clear");

    // A move with non-positive energy change is always accepted
    a_downhill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && $past(r_state) == S_EVAL && r_res.energy_change <= 0)
        |-> r_res.accepted)
        else $error("downhill move rejected");

    // The sequencer leaves idle only on an item beat
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_IDLE && r_state != S_IDLE) |-> $past(start && !busy))
        else $error("sequencer left idle without a start beat");

endmodule
